/* sv/rc4ks_pkg.sv */
// rc4ks_pkg: constants, command codes, controller states and the
// command/status structs shared by the rc4 keystream generator files
// depends on nothing
package rc4ks_pkg;

  // longest key that is stored; longer keys keep their first KEY_MAX bytes
  localparam int KEY_MAX    = 256;
  localparam int KEY_AW     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KEY_CW     = $clog2(KEY_MAX + 1);
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;
  localparam int WORD_W     = 32;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    CMD_LOAD_KEY = 2'd0,
    CMD_BYTE     = 2'd1,
    CMD_WORD     = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WK,
    ST_KS_WJ,
    ST_GEN_J,
    ST_GEN_WI,
    ST_GEN_WJ,
    ST_GEN_OUT
  } state_t;

  // controller to datapath strobes
  typedef struct packed {
    logic key_wr;       // store key byte, bump count
    logic sched_start;  // latch key length, clear count and sweep counter
    logic fill;         // write S[addr] = addr, step addr
    logic ks_read;      // read S[addr] and key[kidx]
    logic ks_j;         // j += S[k] + key, read S[j]
    logic ks_wk;        // write S[k] = S[j]
    logic ks_wj;        // write S[j] = old S[k], step k and kidx, read next
    logic ks_done;      // clear i and j
    logic gen_start;    // clear word accumulator
    logic gen_next;     // i += 1, read S[i]
    logic gen_j;        // j += S[i], read S[j]
    logic gen_wi;       // write S[i] = S[j], read S[S[i]+S[j]]
    logic gen_wj;       // write S[j] = old S[i], shift byte into accumulator
    logic out_load;     // move accumulator into output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic addr_last;    // sweep counter on its last entry
    logic out_free;     // output register empty or being taken
  } dp_stat_t;

endpackage

/* sv/rc4ks_in_if.sv */
// rc4ks_in_if: command channel of the rc4 keystream generator
// depends on nothing
interface rc4ks_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] key_byte;
  logic       key_last;

  modport source (output valid, command, key_byte, key_last, input ready);
  modport sink   (input valid, command, key_byte, key_last, output ready);
endinterface

/* sv/rc4ks_out_if.sv */
// rc4ks_out_if: keystream result channel of the rc4 keystream generator
// depends on nothing
interface rc4ks_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] keystream;

  modport source (output valid, keystream, input ready);
  modport sink   (input valid, keystream, output ready);
endinterface

/* sv/rc4_keystream_generator.sv */
// rc4_keystream_generator: top level of the rc4 keystream engine
// depends on rc4ks_pkg, rc4ks_in_if, rc4ks_out_if, rc4ks_ctrl, rc4ks_datapath
//
//   channel  dir  fields                            beat when
//   in_if    in   command, key_byte, key_last       valid && ready
//   out_if   out  keystream[31:0]                   valid && ready
//
// a byte command is accepted, then reads S[j], swaps S[i] and swaps S[j];
// a word command runs those steps for each of its four bytes; the single-port
// permutation memory sets the pace; a key byte without the last mark leaves
// the engine idle; with it, the key schedule runs an identity fill of all 256
// entries, then a swap sweep; after reset the permutation is swept to identity
// with no input beat taken; the result sits in an output register, so a stalled
// out_if only holds the engine once a second result is ready
module rc4_keystream_generator (
  input logic         clk,
  input logic         rst_n,
  rc4ks_in_if.sink    in_if,
  rc4ks_out_if.source out_if
);

  rc4ks_pkg::ctrl_cmd_t cmd;
  rc4ks_pkg::dp_stat_t  stat;

  // sequencer: owns the input handshake and the step order
  rc4ks_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_command  (in_if.command),
    .in_key_last (in_if.key_last),
    .in_ready    (in_if.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // memories, indices and the result register
  rc4ks_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .key_byte      (in_if.key_byte),
    .out_ready     (out_if.ready),
    .stat          (stat),
    .out_valid     (out_if.valid),
    .out_keystream (out_if.keystream)
  );

endmodule

/* sv/rc4ks_ctrl.sv */
// rc4ks_ctrl: sequencer for reset fill, key schedule and keystream steps
// depends on rc4ks_pkg
module rc4ks_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_command,
  input  logic                 in_key_last,
  output logic                 in_ready,
  input  rc4ks_pkg::dp_stat_t  stat,
  output rc4ks_pkg::ctrl_cmd_t cmd
);

  rc4ks_pkg::state_t state_r, state_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              accept;

  assign in_ready = (state_r == rc4ks_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc4ks_pkg::ST_INIT;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      rc4ks_pkg::ST_INIT: begin
        if (stat.addr_last) state_nxt = rc4ks_pkg::ST_IDLE;
      end
      rc4ks_pkg::ST_IDLE: begin
        if (accept) begin
          case (rc4ks_pkg::cmd_t'(in_command))
            rc4ks_pkg::CMD_LOAD_KEY: begin
              if (in_key_last) state_nxt = rc4ks_pkg::ST_FILL;
            end
            rc4ks_pkg::CMD_BYTE: begin
              state_nxt = rc4ks_pkg::ST_GEN_J;
              cnt_nxt   = 2'd0;
            end
            rc4ks_pkg::CMD_WORD: begin
              state_nxt = rc4ks_pkg::ST_GEN_J;
              cnt_nxt   = 2'd3;
            end
            default: state_nxt = rc4ks_pkg::ST_IDLE;
          endcase
        end
      end
      rc4ks_pkg::ST_FILL: begin
        if (stat.addr_last) state_nxt = rc4ks_pkg::ST_KS_RD;
      end
      rc4ks_pkg::ST_KS_RD:  state_nxt = rc4ks_pkg::ST_KS_J;
      rc4ks_pkg::ST_KS_J:   state_nxt = rc4ks_pkg::ST_KS_WK;
      rc4ks_pkg::ST_KS_WK:  state_nxt = rc4ks_pkg::ST_KS_WJ;
      rc4ks_pkg::ST_KS_WJ: begin
        state_nxt = stat.addr_last ? rc4ks_pkg::ST_IDLE : rc4ks_pkg::ST_KS_J;
      end
      rc4ks_pkg::ST_GEN_J:  state_nxt = rc4ks_pkg::ST_GEN_WI;
      rc4ks_pkg::ST_GEN_WI: state_nxt = rc4ks_pkg::ST_GEN_WJ;
      rc4ks_pkg::ST_GEN_WJ: begin
        if (cnt_r != 2'd0) begin
          state_nxt = rc4ks_pkg::ST_GEN_J;
          cnt_nxt   = cnt_r - 2'd1;
        end else if (stat.out_free) begin
          state_nxt = rc4ks_pkg::ST_IDLE;
        end else begin
          state_nxt = rc4ks_pkg::ST_GEN_OUT;
        end
      end
      rc4ks_pkg::ST_GEN_OUT: begin
        if (stat.out_free) state_nxt = rc4ks_pkg::ST_IDLE;
      end
      default: state_nxt = rc4ks_pkg::ST_IDLE;
    endcase
  end

  // datapath strobes
  always_comb begin
    cmd = '0;
    case (state_r)
      rc4ks_pkg::ST_INIT: cmd.fill = 1'b1;
      rc4ks_pkg::ST_IDLE: begin
        if (accept) begin
          case (rc4ks_pkg::cmd_t'(in_command))
            rc4ks_pkg::CMD_LOAD_KEY: begin
              cmd.key_wr      = 1'b1;
              cmd.sched_start = in_key_last;
            end
            rc4ks_pkg::CMD_BYTE, rc4ks_pkg::CMD_WORD: begin
              cmd.gen_start = 1'b1;
              cmd.gen_next  = 1'b1;
            end
            default: cmd = '0;
          endcase
        end
      end
      rc4ks_pkg::ST_FILL:   cmd.fill    = 1'b1;
      rc4ks_pkg::ST_KS_RD:  cmd.ks_read = 1'b1;
      rc4ks_pkg::ST_KS_J:   cmd.ks_j    = 1'b1;
      rc4ks_pkg::ST_KS_WK:  cmd.ks_wk   = 1'b1;
      rc4ks_pkg::ST_KS_WJ: begin
        cmd.ks_wj   = 1'b1;
        cmd.ks_done = stat.addr_last;
      end
      rc4ks_pkg::ST_GEN_J:  cmd.gen_j  = 1'b1;
      rc4ks_pkg::ST_GEN_WI: cmd.gen_wi = 1'b1;
      rc4ks_pkg::ST_GEN_WJ: begin
        cmd.gen_wj = 1'b1;
        if (cnt_r != 2'd0) cmd.gen_next = 1'b1;
        else               cmd.out_load = stat.out_free;
      end
      rc4ks_pkg::ST_GEN_OUT: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* sv/rc4ks_datapath.sv */
// rc4ks_datapath: permutation and key memories, indices, word accumulator
// and output register; depends on rc4ks_pkg
module rc4ks_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rc4ks_pkg::ctrl_cmd_t              cmd,
  input  logic [7:0]                        key_byte,
  input  logic                              out_ready,
  output rc4ks_pkg::dp_stat_t               stat,
  output logic                              out_valid,
  output logic [rc4ks_pkg::WORD_W-1:0]      out_keystream
);

  // permutation memory, write-first on a same-address read
  rc4ks_pkg::byte_t perm_mem [rc4ks_pkg::PERM_DEPTH];
  rc4ks_pkg::byte_t perm_rd_r;
  rc4ks_pkg::byte_t perm_ra, perm_wa, perm_wd;
  logic             perm_we, perm_re;

  // key memory
  rc4ks_pkg::byte_t               key_mem [rc4ks_pkg::KEY_MAX];
  rc4ks_pkg::byte_t               key_rd_r;
  logic [rc4ks_pkg::KEY_AW-1:0]   key_ra;
  logic                           key_re, key_we, key_room;
  logic [rc4ks_pkg::KEY_CW-1:0]   key_count_r, key_count_nxt, key_count_inc;
  logic [rc4ks_pkg::KEY_CW-1:0]   key_len_r;
  logic [rc4ks_pkg::KEY_AW-1:0]   kidx_r, kidx_step;

  rc4ks_pkg::byte_t               addr_r, i_r, j_r, s_hold_r, t_r;
  rc4ks_pkg::byte_t               j_ks, j_gen, t_sum, ks_byte;
  logic [rc4ks_pkg::WORD_W-1:0]   acc_r, acc_nxt, out_data_r;
  logic                           out_valid_r;

  assign j_ks    = 8'(j_r + perm_rd_r + key_rd_r);
  assign j_gen   = 8'(j_r + perm_rd_r);
  assign t_sum   = 8'(s_hold_r + perm_rd_r);
  // S[t] was read alongside the S[i] write; the S[j] write lands this cycle
  assign ks_byte = (t_r == j_r) ? s_hold_r : perm_rd_r;

  assign stat.addr_last = (addr_r == 8'(rc4ks_pkg::PERM_DEPTH - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  // key index wraps at the stored key length
  assign kidx_step = (rc4ks_pkg::KEY_CW'(kidx_r) + 1'b1 == key_len_r)
                     ? '0 : rc4ks_pkg::KEY_AW'(kidx_r + 1'b1);

  always_comb begin
    perm_re = cmd.ks_read | cmd.ks_j | cmd.ks_wj | cmd.gen_next |
              cmd.gen_j | cmd.gen_wi;
    perm_ra = addr_r;
    if (cmd.ks_wj)    perm_ra = 8'(addr_r + 8'd1);
    if (cmd.ks_j)     perm_ra = j_ks;
    if (cmd.gen_next) perm_ra = 8'(i_r + 8'd1);
    if (cmd.gen_j)    perm_ra = j_gen;
    if (cmd.gen_wi)   perm_ra = t_sum;

    perm_we = cmd.fill | cmd.ks_wk | cmd.ks_wj | cmd.gen_wi | cmd.gen_wj;
    perm_wa = addr_r;
    perm_wd = addr_r;
    if (cmd.ks_wk)               perm_wd = perm_rd_r;
    if (cmd.ks_wj || cmd.gen_wj) begin
      perm_wa = j_r;
      perm_wd = s_hold_r;
    end
    if (cmd.gen_wi) begin
      perm_wa = i_r;
      perm_wd = perm_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (perm_we) perm_mem[perm_wa] <= perm_wd;
    if (perm_re) perm_rd_r <= (perm_we && (perm_wa == perm_ra)) ? perm_wd
                                                                : perm_mem[perm_ra];
  end

  always_comb begin
    key_room      = (key_count_r < rc4ks_pkg::KEY_CW'(rc4ks_pkg::KEY_MAX));
    key_we        = cmd.key_wr && key_room;
    key_count_inc = key_room ? rc4ks_pkg::KEY_CW'(key_count_r + 1'b1) : key_count_r;
    key_count_nxt = key_count_r;
    if (cmd.key_wr) key_count_nxt = cmd.sched_start ? '0 : key_count_inc;
    key_re = cmd.ks_read | cmd.ks_wj;
    key_ra = cmd.ks_wj ? kidx_step : kidx_r;
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_count_r[rc4ks_pkg::KEY_AW-1:0]] <= key_byte;
    if (key_re) key_rd_r <= key_mem[key_ra];
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.gen_start) acc_nxt = '0;
    if (cmd.gen_wj)    acc_nxt = {acc_r[rc4ks_pkg::WORD_W-9:0], ks_byte};
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      key_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      key_count_r <= key_count_nxt;
      if (cmd.sched_start)               addr_r <= '0;
      else if (cmd.fill || cmd.ks_wj)    addr_r <= 8'(addr_r + 8'd1);
      if (cmd.gen_next)                  i_r <= 8'(i_r + 8'd1);
      else if (cmd.ks_done)              i_r <= '0;
      if (cmd.sched_start || cmd.ks_done) j_r <= '0;
      else if (cmd.ks_j)                 j_r <= j_ks;
      else if (cmd.gen_j)                j_r <= j_gen;
      if (cmd.out_load)                  out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.ks_j || cmd.gen_j) s_hold_r <= perm_rd_r;
    if (cmd.gen_wi)            t_r      <= t_sum;
    if (cmd.sched_start)       key_len_r <= key_count_inc;
    if (cmd.sched_start)       kidx_r   <= '0;
    else if (cmd.ks_wj)        kidx_r   <= kidx_step;
    acc_r <= acc_nxt;
    if (cmd.out_load)          out_data_r <= acc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_keystream = out_data_r;

endmodule

/* sv/rc4ks_checker.sv */
// rc4ks_checker: port-level checks on the rc4 keystream generator
// depends on rc4ks_pkg and the top level it is bound to
module rc4ks_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic        in_key_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_keystream
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_keystream))
    else $error("waiting result changed");

  // a byte step keeps the input closed through its read and swap steps
  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == rc4ks_pkg::CMD_BYTE)
    |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input reopened during keystream step");

  // a plain key byte leaves the input ready in the next cycle
  a_key_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == rc4ks_pkg::CMD_LOAD_KEY) && !in_key_last
    |=> in_ready)
    else $error("key byte stalled input");

endmodule

bind rc4_keystream_generator rc4ks_checker u_rc4ks_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_command    (in_if.command),
  .in_key_last   (in_if.key_last),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_keystream (out_if.keystream)
);

/* bench/tb_rc4_keystream_generator.sv */
`timescale 1ns / 100ps
// tb_rc4_keystream_generator: self-checking bench for the rc4 keystream engine
// depends on rc4ks_pkg, rc4ks_in_if, rc4ks_out_if and rc4_keystream_generator
module tb_rc4_keystream_generator;

  // command code that the package leaves out; the engine must drop it
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  // key schedule: identity fill plus the swap sweep, the longest silent stretch
  localparam int SCHED_CYCLES = 256 + 769;
  localparam int DRAIN_CYCLES = SCHED_CYCLES + 64;
  // several schedules' worth of cycles with no beat on either side means a hang
  localparam int STALL_LIMIT  = 8 * SCHED_CYCLES;
  localparam int RANDOM_BEATS = 1000;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst_n;

  rc4ks_in_if  in_if ();
  rc4ks_out_if out_if ();

  rc4_keystream_generator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // 2 ns period, rising edges at odd ns
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // keystream predictor: own copy of permutation, key store and indices
  // ---------------------------------------------------------------------------
  rc4ks_pkg::byte_t             perm_s [rc4ks_pkg::PERM_DEPTH];
  rc4ks_pkg::byte_t             key_mem [rc4ks_pkg::KEY_MAX];
  int unsigned                  key_len;
  rc4ks_pkg::byte_t             idx_i;
  rc4ks_pkg::byte_t             idx_j;
  logic [rc4ks_pkg::WORD_W-1:0] expected_ks [$];

  // idle mix, percent of cycles in which each side holds back
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  int unsigned beats_sent;
  int unsigned undef_sent;
  int unsigned keys_run;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned idle_cycles;

  function automatic void perm_swap(rc4ks_pkg::byte_t a, rc4ks_pkg::byte_t b);
    rc4ks_pkg::byte_t t;
    t         = perm_s[a];
    perm_s[a] = perm_s[b];
    perm_s[b] = t;
  endfunction

  // identity, then one swap per entry with the key reused cyclically
  function automatic void run_key_schedule(int unsigned len);
    rc4ks_pkg::byte_t jj;
    int               k;
    jj = 8'd0;
    for (k = 0; k < rc4ks_pkg::PERM_DEPTH; k++) perm_s[k] = rc4ks_pkg::byte_t'(k);
    for (k = 0; k < rc4ks_pkg::PERM_DEPTH; k++) begin
      jj = jj + perm_s[k] + key_mem[k % len];
      perm_swap(rc4ks_pkg::byte_t'(k), jj);
    end
    idx_i = 8'd0;
    idx_j = 8'd0;
  endfunction

  // one keystream step, all sums wrap at 8 bits
  function automatic rc4ks_pkg::byte_t next_ks_byte();
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm_s[idx_i];
    perm_swap(idx_i, idx_j);
    return perm_s[rc4ks_pkg::byte_t'(perm_s[idx_i] + perm_s[idx_j])];
  endfunction

  function automatic void predict_beat(logic [1:0] cmd, rc4ks_pkg::byte_t kb,
                                       logic last);
    logic [rc4ks_pkg::WORD_W-1:0] w;
    case (cmd)
      rc4ks_pkg::CMD_LOAD_KEY: begin
        // key too long: extra bytes are dropped, the mark still counts
        if (key_len < rc4ks_pkg::KEY_MAX) begin
          key_mem[key_len] = kb;
          key_len++;
        end
        if (last) begin
          run_key_schedule(key_len);
          key_len = 0;
          keys_run++;
        end
      end
      rc4ks_pkg::CMD_BYTE: expected_ks.push_back({24'd0, next_ks_byte()});
      rc4ks_pkg::CMD_WORD: begin
        // first byte ends up most significant
        w = '0;
        repeat (4) w = {w[23:0], next_ks_byte()};
        expected_ks.push_back(w);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // command side: drive at the falling edge, beat seen at the rising edge
  // ---------------------------------------------------------------------------
  // entered and left at a falling edge; valid stays high between
  // back-to-back beats so it never gets two updates in one step
  task automatic send_beat(logic [1:0] cmd, rc4ks_pkg::byte_t kb, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.command  <= cmd;
    in_if.key_byte <= kb;
    in_if.key_last <= last;
    do @(posedge clk); while (!in_if.ready);
    predict_beat(cmd, kb, last);
    if (cmd == CMD_UNDEF) undef_sent++;
    else beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_key(int unsigned len, logic mark_last);
    int unsigned n;
    for (n = 1; n <= len; n++)
      send_beat(rc4ks_pkg::CMD_LOAD_KEY, rc4ks_pkg::byte_t'($urandom),
                mark_last && (n == len));
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the in-order check
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_result
    logic [rc4ks_pkg::WORD_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_ks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected keystream beat: actual %08h", out_if.keystream);
      end else begin
        want = expected_ks.pop_front();
        if (out_if.keystream !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("keystream mismatch: expected %08h actual %08h", want,
                     out_if.keystream);
        end
      end
    end
  end

  // hang detector: counts cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: %0d cycles without a beat, %0d results pending",
                   idle_cycles, expected_ks.size());
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // keystream straight after reset runs on the identity permutation;
  // the undefined command must leave no trace, mark or not
  task automatic test_no_key();
    send_beat(rc4ks_pkg::CMD_BYTE, 8'hff, 1'b1);
    send_beat(rc4ks_pkg::CMD_WORD, 8'h00, 1'b1);
    send_beat(CMD_UNDEF, 8'hff, 1'b1);
    send_beat(CMD_UNDEF, 8'h00, 1'b0);
    send_beat(rc4ks_pkg::CMD_BYTE, 8'h00, 1'b0);
  endtask

  // one-byte keys at both extremes, a classic three-byte key, and a key
  // whose loading is interrupted by keystream commands
  task automatic test_short_keys();
    send_beat(rc4ks_pkg::CMD_LOAD_KEY, 8'h00, 1'b1);
    send_beat(rc4ks_pkg::CMD_WORD, 8'hff, 1'b0);
    send_beat(rc4ks_pkg::CMD_LOAD_KEY, 8'hff, 1'b1);
    send_beat(rc4ks_pkg::CMD_BYTE, 8'h00, 1'b1);
    send_beat(rc4ks_pkg::CMD_WORD, 8'h00, 1'b0);
    send_beat(rc4ks_pkg::CMD_LOAD_KEY, 8'h4b, 1'b0);
    send_beat(rc4ks_pkg::CMD_LOAD_KEY, 8'h65, 1'b0);
    send_beat(rc4ks_pkg::CMD_LOAD_KEY, 8'h79, 1'b1);
    send_beat(rc4ks_pkg::CMD_WORD, 8'h00, 1'b0);
    send_beat(rc4ks_pkg::CMD_BYTE, 8'h00, 1'b0);
    send_beat(rc4ks_pkg::CMD_LOAD_KEY, 8'h5a, 1'b0);
    send_beat(rc4ks_pkg::CMD_BYTE, 8'hff, 1'b1);
    send_beat(rc4ks_pkg::CMD_LOAD_KEY, 8'ha5, 1'b1);
    send_beat(rc4ks_pkg::CMD_WORD, 8'h00, 1'b0);
  endtask

  // longest stored key, then one byte too many with the mark on the
  // dropped byte, then a fresh one-byte key to show the count restarted
  task automatic test_long_key();
    send_key(rc4ks_pkg::KEY_MAX, 1'b1);
    send_beat(rc4ks_pkg::CMD_WORD, 8'h00, 1'b0);
    send_key(rc4ks_pkg::KEY_MAX + 1, 1'b1);
    send_beat(rc4ks_pkg::CMD_WORD, 8'h00, 1'b0);
    send_beat(rc4ks_pkg::CMD_LOAD_KEY, 8'h80, 1'b1);
    send_beat(rc4ks_pkg::CMD_BYTE, 8'h00, 1'b0);
  endtask

  // mostly key-then-keystream sessions with random content; some keys
  // lack the mark so the next session extends them, a few undefined
  // commands sprinkled in, and the three idle mixes in turn
  task automatic test_random();
    int unsigned phase;
    int unsigned phase_end;
    int unsigned len;
    int unsigned pick;
    logic [1:0]  cmd;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 36; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_end = beats_sent + RANDOM_BEATS / 3;
      while (beats_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 80) len = $urandom_range(16, 1);
        else if (pick < 95) len = $urandom_range(64, 17);
        else len = $urandom_range(300, 240);
        send_key(len, $urandom_range(9) != 0);
        repeat ($urandom_range(12, 1)) begin
          pick = $urandom_range(99);
          if (pick < 5) cmd = CMD_UNDEF;
          else if (pick < 55) cmd = rc4ks_pkg::CMD_BYTE;
          else cmd = rc4ks_pkg::CMD_WORD;
          send_beat(cmd, rc4ks_pkg::byte_t'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : run_all
    int k;
    for (k = 0; k < rc4ks_pkg::PERM_DEPTH; k++) perm_s[k] = rc4ks_pkg::byte_t'(k);
    for (k = 0; k < rc4ks_pkg::KEY_MAX; k++) key_mem[k] = 8'd0;
    key_len       = 0;
    idx_i         = 8'd0;
    idx_j         = 8'd0;
    beats_sent    = 0;
    undef_sent    = 0;
    keys_run      = 0;
    results_seen  = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    send_idle_pct = 36;
    recv_idle_pct = 53;

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.command  = CMD_UNDEF;
    in_if.key_byte = 8'd0;
    in_if.key_last = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_no_key();
    test_short_keys();
    test_long_key();
    test_random();

    in_if.valid <= 1'b0;
    // wait out the results, then a full schedule's worth for stragglers
    while (expected_ks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d command beats plus %0d undefined, %0d key schedules",
             beats_sent, undef_sent, keys_run);
    $display("%0d keystream results checked over three idle mixes, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0 && expected_ks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
